// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define CLSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define CLSC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CLSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLSC_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== hw/rtl/clsc_pkg.sv =====
// shared constants and types of the circular list store
package clsc_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;

	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// request action codes
	localparam logic [ACTION_W-1:0] ACT_INS_TAIL = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_INS_HEAD = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SEARCH   = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic                success;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  entry_count;
	} result_t;

endpackage

// ===== hw/rtl/clsc_req_if.sv =====
// request channel of the circular list store
interface clsc_req_if;
	logic                                valid;
	logic                                ready;
	logic        [clsc_pkg::ACTION_W-1:0] action;
	logic signed [clsc_pkg::VALUE_W-1:0]  value;

	modport source(output valid, action, value, input ready);
	modport sink(input valid, action, value, output ready);
endinterface

// ===== hw/rtl/clsc_res_if.sv =====
// result channel of the circular list store
interface clsc_res_if;
	logic                          valid;
	logic                          ready;
	logic                          success;
	logic [clsc_pkg::STATUS_W-1:0] status;
	logic [clsc_pkg::COUNT_W-1:0]  entry_count;

	modport source(output valid, success, status, entry_count, input ready);
	modport sink(input valid, success, status, entry_count, output ready);
endinterface

// ===== hw/rtl/clsc_node_mem.sv =====
// node store: value and link memories with registered read
module clsc_node_mem #(
	parameter int CAPACITY   = clsc_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = clsc_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic [$clog2(CAPACITY)-1:0] rd_addr,
	output logic [VALUE_BITS-1:0]       val_rd,
	output logic [$clog2(CAPACITY)-1:0] link_rd,
	input  logic                        val_we,
	input  logic [$clog2(CAPACITY)-1:0] val_waddr,
	input  logic [VALUE_BITS-1:0]       val_wdata,
	input  logic                        link_we,
	input  logic [$clog2(CAPACITY)-1:0] link_waddr,
	input  logic [$clog2(CAPACITY)-1:0] link_wdata
);
	localparam int AW = $clog2(CAPACITY);

	logic [VALUE_BITS-1:0] vals_q  [CAPACITY];
	logic [AW-1:0]         links_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (val_we) begin
			vals_q[val_waddr] <= val_wdata;
		end
		if (link_we) begin
			links_q[link_waddr] <= link_wdata;
		end
		val_rd  <= vals_q[rd_addr];
		link_rd <= links_q[rd_addr];
	end
endmodule

// ===== hw/rtl/clsc_ctrl.sv =====
// sequencer: link init sweep, insert, list walk with shared compare, unlink
module clsc_ctrl #(
	parameter int CAPACITY   = clsc_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = clsc_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	input  logic        [clsc_pkg::ACTION_W-1:0] req_action,
	input  logic signed [clsc_pkg::VALUE_W-1:0]  req_value,
	output logic                                 req_ready,
	input  logic                                 slot_free,
	output logic                                 res_fire,
	output clsc_pkg::result_t                    res,
	output logic        [$clog2(CAPACITY)-1:0]   rd_addr,
	input  logic        [VALUE_BITS-1:0]         val_rd,
	input  logic        [$clog2(CAPACITY)-1:0]   link_rd,
	output logic                                 val_we,
	output logic        [$clog2(CAPACITY)-1:0]   val_waddr,
	output logic        [VALUE_BITS-1:0]         val_wdata,
	output logic                                 link_we,
	output logic        [$clog2(CAPACITY)-1:0]   link_waddr,
	output logic        [$clog2(CAPACITY)-1:0]   link_wdata
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = clsc_pkg::COUNT_W;

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_INS, S_LINK, S_WALK, S_FREE, S_DONE
	} state_t;

	state_t                          state_q;
	logic [AW-1:0]                   idx_q;
	logic [clsc_pkg::ACTION_W-1:0]   act_q;
	logic [VALUE_BITS-1:0]           val_q;
	logic [AW-1:0]                   head_q, tail_q, free_q, node_q, prev_q;
	logic [CW-1:0]                   count_q, step_q;
	logic                            success_q;
	logic [clsc_pkg::STATUS_W-1:0]   status_q;

	logic          init_last, full, match, walk_last, req_is_ins;
	logic [AW-1:0] idx_next;

	assign init_last  = (idx_q == AW'(CAPACITY - 1));
	assign idx_next   = init_last ? '0 : idx_q + 1'b1;
	assign full       = (count_q == CW'(CAPACITY));
	// the one shared comparator of the walk
	assign match      = (val_rd == val_q);
	assign walk_last  = (step_q == count_q - CW'(1));
	assign req_is_ins = (req_action == clsc_pkg::ACT_INS_TAIL) ||
		(req_action == clsc_pkg::ACT_INS_HEAD);

	assign req_ready = (state_q == S_IDLE);
	assign res_fire  = (state_q == S_DONE) && slot_free;
	assign res       = '{success: success_q, status: status_q, entry_count: EW'(count_q)};

	always_comb begin
		rd_addr    = free_q;
		val_we     = 1'b0;
		val_waddr  = free_q;
		val_wdata  = val_q;
		link_we    = 1'b0;
		link_waddr = node_q;
		link_wdata = free_q;
		case (state_q)
			S_INIT: begin
				link_we    = 1'b1;
				link_waddr = idx_q;
				link_wdata = idx_next;
			end
			S_IDLE: begin
				rd_addr = req_is_ins ? free_q : head_q;
			end
			S_INS: begin
				val_we     = 1'b1;
				link_we    = 1'b1;
				link_waddr = free_q;
				link_wdata = (count_q == '0) ? free_q : head_q;
			end
			S_LINK: begin
				link_we    = 1'b1;
				link_waddr = tail_q;
				link_wdata = node_q;
			end
			S_WALK: begin
				rd_addr = link_rd;
				// bypass the removed node
				if (match && act_q == clsc_pkg::ACT_REMOVE && count_q != CW'(1)) begin
					link_we    = 1'b1;
					link_waddr = prev_q;
					link_wdata = link_rd;
				end
			end
			S_FREE: begin
				link_we    = 1'b1;
				link_waddr = node_q;
				link_wdata = free_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			idx_q     <= '0;
			act_q     <= clsc_pkg::ACT_SEARCH;
			val_q     <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			free_q    <= '0;
			node_q    <= '0;
			prev_q    <= '0;
			count_q   <= '0;
			step_q    <= '0;
			success_q <= 1'b0;
			status_q  <= clsc_pkg::STATUS_OK;
		end else begin
			case (state_q)
				S_INIT: begin
					idx_q <= idx_next;
					if (init_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						act_q  <= req_action;
						val_q  <= VALUE_BITS'(req_value);
						prev_q <= tail_q;
						node_q <= head_q;
						step_q <= '0;
						if (req_is_ins) begin
							if (full) begin
								success_q <= 1'b0;
								status_q  <= clsc_pkg::STATUS_FULL;
								state_q   <= S_DONE;
							end else begin
								state_q <= S_INS;
							end
						end else if (count_q == '0) begin
							success_q <= 1'b0;
							status_q  <= clsc_pkg::STATUS_NOT_FOUND;
							state_q   <= S_DONE;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_INS: begin
					free_q    <= link_rd;
					node_q    <= free_q;
					count_q   <= count_q + 1'b1;
					success_q <= 1'b1;
					status_q  <= clsc_pkg::STATUS_OK;
					if (count_q == '0) begin
						head_q  <= free_q;
						tail_q  <= free_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					if (act_q == clsc_pkg::ACT_INS_TAIL) begin
						tail_q <= node_q;
					end else begin
						head_q <= node_q;
					end
					state_q <= S_DONE;
				end
				S_WALK: begin
					if (match) begin
						success_q <= 1'b1;
						status_q  <= clsc_pkg::STATUS_OK;
						if (act_q == clsc_pkg::ACT_REMOVE) begin
							if (count_q == CW'(1)) begin
								head_q <= '0;
								tail_q <= '0;
							end else begin
								if (node_q == head_q) begin
									head_q <= link_rd;
								end
								if (node_q == tail_q) begin
									tail_q <= prev_q;
								end
							end
							state_q <= S_FREE;
						end else begin
							state_q <= S_DONE;
						end
					end else if (walk_last) begin
						success_q <= 1'b0;
						status_q  <= clsc_pkg::STATUS_NOT_FOUND;
						state_q   <= S_DONE;
					end else begin
						prev_q <= node_q;
						node_q <= link_rd;
						step_q <= step_q + 1'b1;
					end
				end
				S_FREE: begin
					free_q  <= node_q;
					count_q <= count_q - 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== hw/rtl/circular_list_store_core.sv =====
// top level of the circular list store
// circular singly linked list of signed values in a store of CAPACITY nodes,
// with head, tail and free-list head pointers kept in registers and the node
// values and links in two single-port-read memories. after reset the block
// runs a link init sweep over all CAPACITY nodes (node i links to i+1, the
// last to node 0) and takes no request meanwhile. one request is worked at a
// time: an insert goes through the insert and link states (the link state
// is skipped for an empty list, and an insert dropped on a full store goes
// straight to done), a search walks at most the entry count of nodes, and a
// remove that finds its value then passes through the free state. the walk
// visits one node per cycle, set by the registered memory read feeding its
// own next address and the one value comparator. the result sits in an
// output register, so the next request is taken while a result waits; a new
// request is taken in the cycle after the result leaves the sequencer.
`include "assert_macros.svh"

module circular_list_store_core #(
	parameter int CAPACITY   = clsc_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = clsc_pkg::VALUE_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	clsc_req_if.sink  req,
	clsc_res_if.source res
);
	localparam int AW = $clog2(CAPACITY);
	localparam int EW = clsc_pkg::COUNT_W;

	// memory port wires between sequencer and node store
	logic [AW-1:0]         rd_addr;
	logic [VALUE_BITS-1:0] val_rd;
	logic [AW-1:0]         link_rd;
	logic                  val_we;
	logic [AW-1:0]         val_waddr;
	logic [VALUE_BITS-1:0] val_wdata;
	logic                  link_we;
	logic [AW-1:0]         link_waddr;
	logic [AW-1:0]         link_wdata;

	// sequencer result handoff
	logic              slot_free;
	logic              res_fire;
	clsc_pkg::result_t ctrl_res;

	// output register
	logic              res_valid_q;
	clsc_pkg::result_t res_q;

	clsc_node_mem #(
		.CAPACITY  (CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) u_node_mem (
		.clk       (clk),
		.rd_addr   (rd_addr),
		.val_rd    (val_rd),
		.link_rd   (link_rd),
		.val_we    (val_we),
		.val_waddr (val_waddr),
		.val_wdata (val_wdata),
		.link_we   (link_we),
		.link_waddr(link_waddr),
		.link_wdata(link_wdata)
	);

	clsc_ctrl #(
		.CAPACITY  (CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_action(req.action),
		.req_value (req.value),
		.req_ready (req.ready),
		.slot_free (slot_free),
		.res_fire  (res_fire),
		.res       (ctrl_res),
		.rd_addr   (rd_addr),
		.val_rd    (val_rd),
		.link_rd   (link_rd),
		.val_we    (val_we),
		.val_waddr (val_waddr),
		.val_wdata (val_wdata),
		.link_we   (link_we),
		.link_waddr(link_waddr),
		.link_wdata(link_wdata)
	);

	// the output register can take a new result when empty or draining now
	assign slot_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// payload needs no reset, it is qualified by res_valid_q
	always_ff @(posedge clk) begin
		if (res_fire) begin
			res_q <= ctrl_res;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.success     = res_q.success;
	assign res.status      = res_q.status;
	assign res.entry_count = res_q.entry_count;

	// a result never overwrites one still waiting
	`CLSC_ASSERT(a_no_overwrite, clk, arst_n, res_fire |-> slot_free, "result overwritten")
	// one request at a time: busy right after an accept
	`CLSC_ASSERT(a_busy_after_req, clk, arst_n, (req.valid && req.ready) |=> !req.ready, "ready after accept")
	// success goes with status ok and nothing else
	`CLSC_ASSERT(a_success_ok, clk, arst_n, res_valid_q |-> (res_q.success == (res_q.status == clsc_pkg::STATUS_OK)), "success and status disagree")
	// a dropped insert only happens with the store full
	`CLSC_ASSERT(a_full_count, clk, arst_n, (res_valid_q && res_q.status == clsc_pkg::STATUS_FULL) |-> (res_q.entry_count == EW'(CAPACITY)), "full reported below capacity")
endmodule
